### rtl/sie_pkg.sv
// shared widths, types and constants of the segment intersection engine
package sie_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 16;
  // coordinate difference, one bit wider than a coordinate
  localparam int DW = COORD_BITS + 1;
  // cross product of two differences, with one guard bit
  localparam int PW = 2 * DW + 1;
  // product of a direction component and the numerator
  localparam int MW = DW + PW;
  // scale shift: fraction bits plus one rounding bit
  localparam int SH = FRAC_BITS + 1;
  // dividend width, also the number of divider stages
  localparam int NQ = MW + SH;
  // partial remainder width
  localparam int RW = PW + 1;
  // output coordinate width
  localparam int OW = 32;
  // width of the final sum before clamping
  localparam int TW = NQ + 2;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;

  // one classified pair handed from the front to the back
  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    diff_t  d1x;
    diff_t  d1y;
    prod_t  det;
    prod_t  num;
    logic   crosses;
  } job_t;

endpackage

### rtl/sie_front.sv
// front: takes segment pairs, forms cross products and the crossing flag
module sie_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sie_pkg::coord_t     in_first_start_x,
  input  sie_pkg::coord_t     in_first_start_y,
  input  sie_pkg::coord_t     in_first_end_x,
  input  sie_pkg::coord_t     in_first_end_y,
  input  sie_pkg::coord_t     in_second_start_x,
  input  sie_pkg::coord_t     in_second_start_y,
  input  sie_pkg::coord_t     in_second_end_x,
  input  sie_pkg::coord_t     in_second_end_y,
  input  logic                q_full,
  output logic                push,
  output sie_pkg::job_t       push_job
);

  function automatic sie_pkg::prod_t cross2(sie_pkg::diff_t ax, sie_pkg::diff_t ay,
                                            sie_pkg::diff_t bx, sie_pkg::diff_t by);
    logic signed [2*sie_pkg::DW-1:0] m0;
    logic signed [2*sie_pkg::DW-1:0] m1;
    m0 = ax * by;
    m1 = ay * bx;
    return sie_pkg::prod_t'(m0) - sie_pkg::prod_t'(m1);
  endfunction

  logic fe;
  logic v1_r, v2_r;

  sie_pkg::coord_t p1x_r, p1y_r, p1x2_r, p1y2_r;
  sie_pkg::diff_t  d1x_r, d1y_r, d2x_r, d2y_r, ex_r, ey_r, fx_r, fy_r, hx_r, hy_r;
  sie_pkg::diff_t  d1x2_r, d1y2_r;
  sie_pkg::prod_t  det_r, num_r, c1_r, c2_r, c4_r;

  assign fe       = !q_full;
  assign in_stall = !fe;
  assign push     = fe && v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      p1x_r <= in_first_start_x;
      p1y_r <= in_first_start_y;
      d1x_r <= sie_pkg::diff_t'(in_first_end_x) - sie_pkg::diff_t'(in_first_start_x);
      d1y_r <= sie_pkg::diff_t'(in_first_end_y) - sie_pkg::diff_t'(in_first_start_y);
      d2x_r <= sie_pkg::diff_t'(in_second_end_x) - sie_pkg::diff_t'(in_second_start_x);
      d2y_r <= sie_pkg::diff_t'(in_second_end_y) - sie_pkg::diff_t'(in_second_start_y);
      ex_r  <= sie_pkg::diff_t'(in_second_start_x) - sie_pkg::diff_t'(in_first_start_x);
      ey_r  <= sie_pkg::diff_t'(in_second_start_y) - sie_pkg::diff_t'(in_first_start_y);
      fx_r  <= sie_pkg::diff_t'(in_second_end_x) - sie_pkg::diff_t'(in_first_start_x);
      fy_r  <= sie_pkg::diff_t'(in_second_end_y) - sie_pkg::diff_t'(in_first_start_y);
      hx_r  <= sie_pkg::diff_t'(in_first_end_x) - sie_pkg::diff_t'(in_second_start_x);
      hy_r  <= sie_pkg::diff_t'(in_first_end_y) - sie_pkg::diff_t'(in_second_start_y);

      // side of the first segment's line for each end of the second
      c1_r   <= cross2(d1x_r, d1y_r, ex_r, ey_r);
      c2_r   <= cross2(d1x_r, d1y_r, fx_r, fy_r);
      // side of the second segment's line for the first's end point
      c4_r   <= cross2(d2x_r, d2y_r, hx_r, hy_r);
      det_r  <= cross2(d1x_r, d1y_r, d2x_r, d2y_r);
      // also the side test of the first's start point, with sign kept
      num_r  <= cross2(ex_r, ey_r, d2x_r, d2y_r);
      p1x2_r <= p1x_r;
      p1y2_r <= p1y_r;
      d1x2_r <= d1x_r;
      d1y2_r <= d1y_r;
    end
  end

  logic opp_a, opp_b;
  assign opp_a = (c1_r < 0 && c2_r > 0) || (c1_r > 0 && c2_r < 0);
  assign opp_b = (num_r < 0 && c4_r > 0) || (num_r > 0 && c4_r < 0);

  always_comb begin
    push_job.p1x     = p1x2_r;
    push_job.p1y     = p1y2_r;
    push_job.d1x     = d1x2_r;
    push_job.d1y     = d1y2_r;
    push_job.det     = det_r;
    push_job.num     = num_r;
    push_job.crosses = opp_a && opp_b;
  end

endmodule

### rtl/sie_queue.sv
// small register queue between the front and the back
module sie_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sie_pkg::job_t   push_job,
  input  logic            pop,
  output sie_pkg::job_t   head_job,
  output logic            full,
  output logic            empty
);

  sie_pkg::job_t             mem_r [sie_pkg::QDEPTH];
  logic [sie_pkg::QAW-1:0]   wr_r, rd_r;
  logic [sie_pkg::QAW:0]     cnt_r;

  assign full     = cnt_r == (sie_pkg::QAW+1)'(sie_pkg::QDEPTH);
  assign empty    = cnt_r == '0;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

endmodule

### rtl/sie_back.sv
// back: scaled products, pipelined division, rounding and clamping
module sie_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sie_pkg::job_t                 head_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [sie_pkg::OW-1:0] out_cross_x,
  output logic signed [sie_pkg::OW-1:0] out_cross_y,
  output logic                          out_segments_cross,
  output logic                          out_lines_parallel,
  output logic                          out_point_saturated
);

  localparam int WW = sie_pkg::RW + sie_pkg::NQ;
  localparam logic signed [sie_pkg::TW-1:0] MAXV =
    sie_pkg::TW'(2**(sie_pkg::OW-1) - 1);
  localparam logic signed [sie_pkg::TW-1:0] MINV = -MAXV - 1;

  typedef struct packed {
    logic [WW-1:0]        wx;
    logic [WW-1:0]        wy;
    logic [sie_pkg::PW-1:0] dv;
    logic                 negx;
    logic                 negy;
    sie_pkg::coord_t      bx;
    sie_pkg::coord_t      by;
    logic                 par;
    logic                 crosses;
  } dstg_t;

  function automatic logic [WW-1:0] div_step(logic [WW-1:0] w, logic [sie_pkg::PW-1:0] d);
    logic [WW-1:0] s;
    s = w << 1;
    if (s[WW-1:sie_pkg::NQ] >= sie_pkg::RW'(d)) begin
      s[WW-1:sie_pkg::NQ] = s[WW-1:sie_pkg::NQ] - sie_pkg::RW'(d);
      s[0] = 1'b1;
    end
    return s;
  endfunction

  // one divider stage: both axes step, everything else rides along
  function automatic dstg_t div_stage(dstg_t s);
    dstg_t n;
    n    = s;
    n.wx = div_step(s.wx, s.dv);
    n.wy = div_step(s.wy, s.dv);
    return n;
  endfunction

  // returns {saturated, coordinate}
  function automatic logic [sie_pkg::OW:0] finish(logic [WW-1:0] w, logic neg,
                                                   sie_pkg::coord_t base);
    logic [sie_pkg::NQ:0]            t;
    logic signed [sie_pkg::TW-1:0]   mag;
    logic signed [sie_pkg::TW-1:0]   tot;
    logic [sie_pkg::OW:0]            res;
    if (neg) begin
      t = {1'b0, w[sie_pkg::NQ-1:0]}
          + (sie_pkg::NQ+1)'(w[WW-1:sie_pkg::NQ] != '0);
    end else begin
      t = {1'b0, w[sie_pkg::NQ-1:0]} + (sie_pkg::NQ+1)'(1);
    end
    mag = signed'(sie_pkg::TW'(t >> 1));
    tot = sie_pkg::TW'(base) <<< sie_pkg::FRAC_BITS;
    tot = neg ? tot - mag : tot + mag;
    if (tot > MAXV)      res = {1'b1, sie_pkg::OW'(MAXV)};
    else if (tot < MINV) res = {1'b1, sie_pkg::OW'(MINV)};
    else                 res = {1'b0, tot[sie_pkg::OW-1:0]};
    return res;
  endfunction

  logic  adv;
  logic  v_r [sie_pkg::NQ+1];
  dstg_t s_r [sie_pkg::NQ+1];

  logic                      out_valid_r;
  logic signed [sie_pkg::OW-1:0] cx_r, cy_r;
  logic                      cr_r, par_r, sat_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !q_empty;

  // stage zero: magnitudes, signs and the scaled products
  logic [sie_pkg::DW-1:0] adx, ady;
  logic [sie_pkg::PW-1:0] anum, adet;
  logic [sie_pkg::MW-1:0] prx, pry;

  always_comb begin
    adx  = head_job.d1x < 0 ? sie_pkg::DW'(-head_job.d1x) : sie_pkg::DW'(head_job.d1x);
    ady  = head_job.d1y < 0 ? sie_pkg::DW'(-head_job.d1y) : sie_pkg::DW'(head_job.d1y);
    anum = head_job.num < 0 ? sie_pkg::PW'(-head_job.num) : sie_pkg::PW'(head_job.num);
    adet = head_job.det < 0 ? sie_pkg::PW'(-head_job.det) : sie_pkg::PW'(head_job.det);
    prx  = sie_pkg::MW'(adx) * sie_pkg::MW'(anum);
    pry  = sie_pkg::MW'(ady) * sie_pkg::MW'(anum);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0].wx      <= {sie_pkg::RW'(0), prx, sie_pkg::SH'(0)};
      s_r[0].wy      <= {sie_pkg::RW'(0), pry, sie_pkg::SH'(0)};
      s_r[0].dv      <= adet;
      s_r[0].negx    <= ((head_job.d1x < 0) != (head_job.num < 0)) != (head_job.det < 0);
      s_r[0].negy    <= ((head_job.d1y < 0) != (head_job.num < 0)) != (head_job.det < 0);
      s_r[0].bx      <= head_job.p1x;
      s_r[0].by      <= head_job.p1y;
      s_r[0].par     <= head_job.det == '0;
      s_r[0].crosses <= head_job.crosses;
      // one quotient bit per stage for both axes
      for (int k = 0; k < sie_pkg::NQ; k++) begin
        s_r[k+1] <= div_stage(s_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= sie_pkg::NQ; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= pop;
      for (int k = 0; k < sie_pkg::NQ; k++) v_r[k+1] <= v_r[k];
    end
  end

  logic [sie_pkg::OW:0] fx, fy;
  assign fx = finish(s_r[sie_pkg::NQ].wx, s_r[sie_pkg::NQ].negx, s_r[sie_pkg::NQ].bx);
  assign fy = finish(s_r[sie_pkg::NQ].wy, s_r[sie_pkg::NQ].negy, s_r[sie_pkg::NQ].by);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v_r[sie_pkg::NQ];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      par_r <= s_r[sie_pkg::NQ].par;
      cr_r  <= s_r[sie_pkg::NQ].crosses && !s_r[sie_pkg::NQ].par;
      if (s_r[sie_pkg::NQ].par) begin
        cx_r  <= '0;
        cy_r  <= '0;
        sat_r <= 1'b0;
      end else begin
        cx_r  <= fx[sie_pkg::OW-1:0];
        cy_r  <= fy[sie_pkg::OW-1:0];
        sat_r <= fx[sie_pkg::OW] || fy[sie_pkg::OW];
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cross_x         = cx_r;
  assign out_cross_y         = cy_r;
  assign out_segments_cross  = cr_r;
  assign out_lines_parallel  = par_r;
  assign out_point_saturated = sat_r;

endmodule

### rtl/segment_intersection_engine_core.sv
// top level of the segment intersection engine
// takes one pair of 2-D segments per request and returns one result per
// request in order: a strict crossing flag, the crossing point of the two
// lines in signed fixed point with 8 fraction bits (rounded to nearest, ties
// up, clamped to 32 bits with point_saturated set) and a parallel flag, with
// a zero point, whenever the determinant is zero. a new request is taken
// every cycle while in_stall is low. from an accepted request to its result
// the path runs through two front stages, the queue, one product stage, a
// 61-stage restoring divider that makes one quotient bit per stage for both
// axes, and the output register. a stall on the result side backs up the
// back end first; the four-entry queue keeps the front taking requests until
// it fills.
module segment_intersection_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sie_pkg::coord_t               in_first_start_x,
  input  sie_pkg::coord_t               in_first_start_y,
  input  sie_pkg::coord_t               in_first_end_x,
  input  sie_pkg::coord_t               in_first_end_y,
  input  sie_pkg::coord_t               in_second_start_x,
  input  sie_pkg::coord_t               in_second_start_y,
  input  sie_pkg::coord_t               in_second_end_x,
  input  sie_pkg::coord_t               in_second_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [sie_pkg::OW-1:0] out_cross_x,
  output logic signed [sie_pkg::OW-1:0] out_cross_y,
  output logic                          out_segments_cross,
  output logic                          out_lines_parallel,
  output logic                          out_point_saturated
);

  // front to queue
  logic          push;
  sie_pkg::job_t push_job;
  logic          q_full;
  // queue to back
  logic          pop;
  logic          q_empty;
  sie_pkg::job_t head_job;

  // cross products and crossing test
  sie_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_start_x  (in_first_start_x),
    .in_first_start_y  (in_first_start_y),
    .in_first_end_x    (in_first_end_x),
    .in_first_end_y    (in_first_end_y),
    .in_second_start_x (in_second_start_x),
    .in_second_start_y (in_second_start_y),
    .in_second_end_x   (in_second_end_x),
    .in_second_end_y   (in_second_end_y),
    .q_full            (q_full),
    .push              (push),
    .push_job          (push_job)
  );

  // decouples the front from the divider pipeline
  sie_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // point computation and result register
  sie_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cross_x         (out_cross_x),
    .out_cross_y         (out_cross_y),
    .out_segments_cross  (out_segments_cross),
    .out_lines_parallel  (out_lines_parallel),
    .out_point_saturated (out_point_saturated)
  );

  // parallel lines give a zero point and no crossing
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lines_parallel |->
      out_cross_x == '0 && out_cross_y == '0 && !out_segments_cross &&
      !out_point_saturated)
    else $error("parallel result carries a point or flag");

  // a clamped coordinate sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_saturated |->
      out_cross_x == 32'sh7fffffff || out_cross_x == 32'sh80000000 ||
      out_cross_y == 32'sh7fffffff || out_cross_y == 32'sh80000000)
    else $error("saturation flag without a clamped coordinate");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
